/* src/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants of the max-heap priority queue
// Holds the key width, the default capacity, the operation and status codes,
// and the structs that travel between the top level and the cell row.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    // Key width and default number of entries
    localparam int DATA_W           = 32;
    localparam int DEFAULT_CAPACITY = 64;
    localparam int COUNT_W          = $clog2(DEFAULT_CAPACITY + 1);

    // Operation carried by an input transaction
    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } opcode_t;

    // Outcome reported with each result transaction
    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [DATA_W-1:0] key;
    } cell_ctrl_t;

    // What one cell shows its neighbors
    typedef struct packed {
        logic              keep;   // holds an entry not smaller than the key
        logic [DATA_W-1:0] value;  // current entry
    } link_t;

endpackage

/* src/mhpq_in_if.sv */
// ----------------------------------------------------------------------------
// mhpq_in_if: request channel of the priority queue
// Valid/ready channel that carries an operation and the key to insert.
// ----------------------------------------------------------------------------
interface mhpq_in_if import mhpq_pkg::*; ();

    logic                     valid;
    logic                     ready;
    opcode_t                  opcode;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);

endinterface

/* src/mhpq_out_if.sv */
// ----------------------------------------------------------------------------
// mhpq_out_if: result channel of the priority queue
// Valid/ready channel that carries status, removed key, new top and count.
// ----------------------------------------------------------------------------
interface mhpq_out_if import mhpq_pkg::*; #(
    parameter int CNT_W = COUNT_W
) ();

    logic                     valid;
    logic                     ready;
    status_t                  status;
    logic signed [DATA_W-1:0] removed_value;
    logic signed [DATA_W-1:0] top_value;
    logic                     top_valid;
    logic [CNT_W-1:0]         entry_count;

    modport source (output valid, output status, output removed_value, output top_value,
                    output top_valid, output entry_count, input ready);
    modport sink   (input valid, input status, input removed_value, input top_value,
                    input top_valid, input entry_count, output ready);

endinterface

/* src/mhpq_cell.sv */
// ----------------------------------------------------------------------------
// mhpq_cell: one slot of the sorted cell row
// Holds one key. The row is kept in descending order from cell 0. On insert
// a cell keeps its key, takes the new key, or takes its left neighbor's key;
// on remove it takes its right neighbor's key.
// ----------------------------------------------------------------------------
module mhpq_cell import mhpq_pkg::*; #(
    parameter int IDX   = 0,
    parameter int CNT_W = COUNT_W
) (
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic [CNT_W-1:0]         count,
    input  link_t                    left,
    input  link_t                    right,
    output link_t                    link,
    output logic signed [DATA_W-1:0] value_next
);

    logic signed [DATA_W-1:0] val_reg;
    logic                     occupied;

    // Slot is in use when it lies below the fill count
    assign occupied = CNT_W'(IDX) < count;

    // Entry stays in place when it is not smaller than the key being inserted
    assign link.keep  = occupied && (val_reg >= $signed(ctrl.key));
    assign link.value = val_reg;

    // Next key: keep, take the new key, or shift from a neighbor
    always_comb
    begin
        value_next = val_reg;
        if (ctrl.ins)
        begin
            if (!link.keep)
            begin
                value_next = left.keep ? $signed(ctrl.key) : $signed(left.value);
            end
        end
        else if (ctrl.rem)
        begin
            value_next = $signed(right.value);
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= value_next;
    end

endmodule

/* src/max_heap_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core: priority queue returning the maximum key
// Insert and remove-maximum over signed 32-bit keys, built as a sorted row
// of cells with a registered result stage.
// ----------------------------------------------------------------------------
// The queue takes one transaction per clock while ready and registers each
// result. Every cell compares its own key against the incoming key and picks
// its next key from itself, the new key or a neighbor, so all cells update
// together in the accepting cycle; the per-cell compare plus the neighbor
// select sets the clock path. The request side stays ready while the result
// register is empty or being drained. An insert into a full queue reports
// full and changes nothing; a remove from an empty queue reports empty. Each
// result carries the removed maximum, the new maximum and the entry count.
// Reset clears the count and the result valid flag; key storage needs no clearing.
module max_heap_priority_queue_core import mhpq_pkg::*; #(
    parameter int HEAP_CAPACITY = DEFAULT_CAPACITY
) (
    input  logic       clk,
    input  logic       rst_n,
    mhpq_in_if.sink    req,
    mhpq_out_if.source rsp
);

    localparam int CNT_W = $clog2(HEAP_CAPACITY + 1);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic signed [DATA_W-1:0] removed_reg;
    logic signed [DATA_W-1:0] removed_next;
    logic signed [DATA_W-1:0] top_reg;
    logic signed [DATA_W-1:0] top_next;
    logic                     top_valid_reg;
    logic [CNT_W-1:0]         count_out_reg;

    logic                     accept;
    logic                     full;
    logic                     empty;
    cell_ctrl_t               ctrl;
    link_t                    lnk [HEAP_CAPACITY];
    logic signed [DATA_W-1:0] cell_next [HEAP_CAPACITY];
    link_t                    edge_left;
    link_t                    edge_right;
    logic signed [DATA_W-1:0] head_next;

    // Handshake
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = count_reg == CNT_W'(HEAP_CAPACITY);
    assign empty     = count_reg == '0;

    // Row boundaries: the new key lands in cell 0 when nothing is kept
    assign edge_left  = '{keep: 1'b1, value: '0};
    assign edge_right = '{keep: 1'b0, value: '0};

    // Cell row
    for (genvar i = 0; i < HEAP_CAPACITY; i++)
    begin : g_cell
        link_t left_l;
        link_t right_l;

        if (i == 0)
        begin : g_first
            assign left_l = edge_left;
        end
        else
        begin : g_mid_l
            assign left_l = lnk[i-1];
        end

        if (i == HEAP_CAPACITY - 1)
        begin : g_last
            assign right_l = edge_right;
        end
        else
        begin : g_mid_r
            assign right_l = lnk[i+1];
        end

        mhpq_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .left       (left_l),
            .right      (right_l),
            .link       (lnk[i]),
            .value_next (cell_next[i])
        );
    end

    // New head of the row
    assign head_next = cell_next[0];

    // Operation decode and result values
    always_comb
    begin
        ctrl         = '{ins: 1'b0, rem: 1'b0, key: req.value};
        status_next  = STATUS_DONE;
        count_next   = count_reg;
        removed_next = '0;
        if (accept)
        begin
            case (req.opcode)
                OP_INSERT:
                begin
                    if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        ctrl.ins   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_REMOVE:
                begin
                    if (empty)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        ctrl.rem     = 1'b1;
                        count_next   = count_reg - CNT_W'(1);
                        removed_next = $signed(lnk[0].value);
                    end
                end
                default:
                begin
                end
            endcase
        end
        top_next = (count_next != '0) ? head_next : '0;
    end

    // Result register fill and drain
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            removed_reg   <= removed_next;
            top_reg       <= top_next;
            top_valid_reg <= count_next != '0;
            count_out_reg <= count_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.removed_value = removed_reg;
    assign rsp.top_value     = top_reg;
    assign rsp.top_valid     = top_valid_reg;
    assign rsp.entry_count   = count_out_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(HEAP_CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.opcode == OP_INSERT && !full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the count");

    a_top_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (top_valid_reg == (count_out_reg != '0)))
        else $error("top flag disagrees with count");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STATUS_EMPTY)
        |-> (removed_reg == '0 && !top_valid_reg && count_out_reg == '0))
        else $error("empty remove reported data");

endmodule
